// ----- rtl/tcpc_pkg.sv -----
// ----------------------------------------------------------------------------
// tcpc_pkg: shared types and helpers for the TCP pseudo-header checksum unit
// Beat layouts of both channels, the protocol reset value and the
// end-around-carry fold used by the input stage and the accumulator.
// ----------------------------------------------------------------------------
package tcpc_pkg;

  localparam int unsigned WORD_W = 16;
  localparam int unsigned BYTE_W = 8;
  // Wide enough for up to eight 16-bit terms before folding
  localparam int unsigned SUM_W  = WORD_W + 3;

  localparam logic [BYTE_W-1:0] PROTOCOL_RESET = 8'd6;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        has_byte;
    logic        first_item;
    logic        last_item;
    logic [31:0] src_address;
    logic [31:0] dst_address;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] checksum_value;
    logic [15:0] segment_length;
  } out_beat_t;

  // Beat held in the input stage, with the pseudo-header sum already formed
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              has_byte;
    logic              first_item;
    logic              last_item;
    logic [WORD_W-1:0] pseudo_sum;
  } stage_beat_t;

  // Fold a multi-term sum to 16 bits with end-around carry
  function automatic logic [WORD_W-1:0] fold_sum(input logic [SUM_W-1:0] total);
    logic [WORD_W:0] once;
    logic [WORD_W:0] twice;
    once  = {1'b0, total[WORD_W-1:0]} + (WORD_W+1)'(total[SUM_W-1:WORD_W]);
    twice = {1'b0, once[WORD_W-1:0]} + (WORD_W+1)'(once[WORD_W]);
    return twice[WORD_W-1:0];
  endfunction

endpackage

// ----- rtl/tcpc_core.sv -----
// ----------------------------------------------------------------------------
// tcpc_core: running checksum accumulator and result register
// Pairs segment bytes into words, keeps the folded sum, count and pending
// high byte, and on the last beat pads, adds the length and complements.
// ----------------------------------------------------------------------------
module tcpc_core
  import tcpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  stage_beat_t item,
  output logic        out_valid,
  input  logic        out_ready,
  output out_beat_t   out_data
);

  logic [WORD_W-1:0] running_sum;
  logic [WORD_W-1:0] byte_count;
  logic              odd_phase;
  logic [BYTE_W-1:0] pending_high_byte;

  logic              advance;
  logic [WORD_W-1:0] base_sum;
  logic [WORD_W-1:0] base_count;
  logic              base_odd;
  logic [BYTE_W-1:0] base_pending;
  logic [WORD_W-1:0] pair_word;
  logic              odd_next;
  logic [BYTE_W-1:0] pending_next;
  logic [WORD_W-1:0] count_next;
  logic [WORD_W-1:0] pad_word;
  logic [WORD_W-1:0] sum_next;
  logic [WORD_W-1:0] final_sum;

  // Stall only a last beat while the result register is still full
  assign item_ready = !item.last_item || !out_valid || out_ready;
  assign advance    = item_valid && item_ready;

  // Start a new segment from the pseudo-header, else continue the state
  always_comb begin
    if (item.first_item) begin
      base_sum     = item.pseudo_sum;
      base_count   = '0;
      base_odd     = 1'b0;
      base_pending = '0;
    end else begin
      base_sum     = running_sum;
      base_count   = byte_count;
      base_odd     = odd_phase;
      base_pending = pending_high_byte;
    end
  end

  // Pair bytes into big-endian words
  always_comb begin
    pair_word    = '0;
    odd_next     = base_odd;
    pending_next = base_pending;
    count_next   = base_count;
    if (item.has_byte) begin
      count_next = base_count + WORD_W'(1);
      if (base_odd) begin
        pair_word    = {base_pending, item.data_byte};
        odd_next     = 1'b0;
        pending_next = '0;
      end else begin
        odd_next     = 1'b1;
        pending_next = item.data_byte;
      end
    end
    pad_word  = odd_next ? {pending_next, BYTE_W'(0)} : '0;
    sum_next  = fold_sum(SUM_W'(base_sum) + SUM_W'(pair_word));
    final_sum = fold_sum(SUM_W'(base_sum) + SUM_W'(pair_word)
                         + SUM_W'(pad_word) + SUM_W'(count_next));
  end

  // Advance the segment state; clear it after a result
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum       <= '0;
      byte_count        <= '0;
      odd_phase         <= 1'b0;
      pending_high_byte <= '0;
    end else if (advance) begin
      if (item.last_item) begin
        running_sum       <= '0;
        byte_count        <= '0;
        odd_phase         <= 1'b0;
        pending_high_byte <= '0;
      end else begin
        running_sum       <= sum_next;
        byte_count        <= count_next;
        odd_phase         <= odd_next;
        pending_high_byte <= pending_next;
      end
    end
  end

  // Hold the result beat until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && item.last_item) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item.last_item) begin
      out_data.checksum_value <= ~final_sum;
      out_data.segment_length <= count_next;
    end
  end

  // A last beat always produces a pending result
  assert property (@(posedge clk) disable iff (rst)
    (advance && item.last_item) |=> out_valid)
    else $error("result not registered after last beat");

  // A result clears the segment state
  assert property (@(posedge clk) disable iff (rst)
    (advance && item.last_item) |=>
      (running_sum == '0 && byte_count == '0 && !odd_phase))
    else $error("segment state not cleared after result");

  // No waiting byte means no pending high byte
  assert property (@(posedge clk) disable iff (rst)
    !odd_phase |-> (pending_high_byte == '0))
    else $error("pending byte without odd phase");

  // A full, stalled result register blocks the next last beat
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready && item_valid && item.last_item) |-> !advance)
    else $error("result overwritten while stalled");

endmodule

// ----- rtl/tcp_pseudo_header_checksum_unit.sv -----
// ----------------------------------------------------------------------------
// tcp_pseudo_header_checksum_unit: TCP checksum over IPv4 pseudo-header
// Usage:
//   in channel  : one segment byte per beat in network order. The beat with
//                 first_item set carries the source and destination address
//                 and restarts the sum; has_byte low adds no byte.
//   out channel : one beat per last_item beat, with the complemented folded
//                 sum and the segment length modulo 65536.
//   cfg channel : writes the 8-bit protocol number (reset value 6); write
//                 only while no segment is in flight. Always ready.
//   Throughput  : one input beat per cycle save a last beat stalled by a
//                 full result; set by the accumulator's single add-and-fold.
//   Result path : an accepted last beat passes the input register, then
//                 the result register, before its result shows.
//   Reset       : sync, active high; clears the sum, count and both valids
//                 and restores the protocol number.
//   Stall       : while the result waits, non-last beats keep flowing; a
//                 further last beat holds in the input register.
// ----------------------------------------------------------------------------
module tcp_pseudo_header_checksum_unit
  import tcpc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_beat_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_beat_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  logic [BYTE_W-1:0] protocol_number;
  logic              stage_valid;
  logic              stage_ready;
  stage_beat_t       stage;
  logic [WORD_W-1:0] pseudo_sum;

  assign cfg_ready = 1'b1;

  // Hold the protocol register
  always_ff @(posedge clk) begin
    if (rst) begin
      protocol_number <= PROTOCOL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      protocol_number <= cfg_data;
    end
  end

  // Form the pseudo-header sum on the way in
  assign pseudo_sum = fold_sum(SUM_W'(in_data.src_address[31:16])
                               + SUM_W'(in_data.src_address[15:0])
                               + SUM_W'(in_data.dst_address[31:16])
                               + SUM_W'(in_data.dst_address[15:0])
                               + SUM_W'(protocol_number));

  assign in_ready = !stage_valid || stage_ready;

  // Input register: take a beat whenever the stage is empty or draining
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage.data_byte  <= in_data.data_byte;
      stage.has_byte   <= in_data.has_byte;
      stage.first_item <= in_data.first_item;
      stage.last_item  <= in_data.last_item;
      stage.pseudo_sum <= pseudo_sum;
    end
  end

  tcpc_core u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (stage_valid),
    .item_ready (stage_ready),
    .item       (stage),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
